FILE: rtl/twh_pkg.sv
`default_nettype none

package twh_pkg;

  // Field and register widths
  localparam int HASH_W     = 32;
  localparam int HALF_W     = 16;
  localparam int WORD_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  // Request function codes
  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_DATA  = 1'b1
  } func_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_LAST  = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/twh_if.sv
`default_nettype none

// Request channel: function code and data word
interface twh_req_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [twh_pkg::WORD_W-1:0]     data_word;

  modport source (output valid, func, data_word, input ready);
  modport sink   (input valid, func, data_word, output ready);
endinterface

// Result channel: running hash and completion flag
interface twh_res_if;
  logic                           valid;
  logic                           ready;
  logic [twh_pkg::HASH_W-1:0]     hash_value;
  logic                           done_res;

  modport source (output valid, hash_value, done_res, input ready);
  modport sink   (input valid, hash_value, done_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/two_pass_word_hash.sv
// Two-pass word hash over a stream of 16-bit little-endian words.
// Channels: req (func, data_word) in, res (hash_value, done_res) out, both
// valid/ready; a request moves when valid and ready are high at a clock edge.
// Every request gives exactly one result. A start request clears the hash and
// loads the countdown from word_count; the word stream then goes in twice.
// done_res rises on the result of the last word of pass two.
// Configuration: cfg_we with cfg_index (0 word_count, 1 mask_last_byte) and
// cfg_data; write only while no request is in flight.
// A request taken goes through the input register, then the result register.
// Throughput: one request per cycle unless the receiver stalls; the hash update
// between them is a 32-bit add, a compare, a subtract and three 16-bit adds.
// Reset (rst, synchronous): pipeline empty, hash 0, block complete, so data
// words before a start just return hash 0 with done_res set.
// When the receiver stalls the result register holds, the input register
// fills, and req.ready drops only once both are occupied.
`default_nettype none

module two_pass_word_hash (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [twh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [twh_pkg::CFG_DATA_W-1:0]     cfg_data,
  twh_req_if.sink                                 req,
  twh_res_if.source                               res
);

  // Configuration registers
  logic [twh_pkg::COUNT_W-1:0] word_count;
  logic                        mask_last_byte;

  // Input register
  logic                        s1_valid;
  logic                        s1_func;
  logic [twh_pkg::WORD_W-1:0]  s1_word;

  // Hash state
  logic [twh_pkg::HASH_W-1:0]  hash_acc, hash_acc_next;
  logic [twh_pkg::COUNT_W-1:0] words_left, words_left_next;
  logic                        second_pass, second_pass_next;
  logic                        complete, complete_next;

  // Result register
  logic                        o_valid;
  logic [twh_pkg::HASH_W-1:0]  o_hash;
  logic                        o_done;

  logic                        advance;
  logic                        step;
  logic [twh_pkg::WORD_W-1:0]  word_eff;
  logic [twh_pkg::HASH_W-1:0]  mixed;
  logic [twh_pkg::COUNT_W-1:0] left_dec;

  // Handshake: result register empties or moves on, input register follows
  assign advance   = !o_valid || res.ready;
  assign step      = s1_valid && advance;
  assign req.ready = !s1_valid || advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count     <= '0;
      mask_last_byte <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        twh_pkg::REG_WORD_COUNT: word_count     <= cfg_data[twh_pkg::COUNT_W-1:0];
        twh_pkg::REG_MASK_LAST:  mask_last_byte <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      s1_func <= req.func;
      s1_word <= req.data_word;
    end
  end

  // Last word of a pass may keep only its low byte
  always_comb begin
    word_eff = s1_word;
    if (mask_last_byte && words_left == twh_pkg::COUNT_W'(1)) begin
      word_eff = {{(twh_pkg::WORD_W-twh_pkg::BYTE_W){1'b0}}, s1_word[twh_pkg::BYTE_W-1:0]};
    end
  end

  twh_mix u_mix (
    .hash_in  (hash_acc),
    .word     (word_eff),
    .count    (words_left[twh_pkg::HALF_W-1:0]),
    .hash_out (mixed)
  );

  assign left_dec = words_left - 1'b1;

  // Next state for the request in the input register
  always_comb begin
    hash_acc_next    = hash_acc;
    words_left_next  = words_left;
    second_pass_next = second_pass;
    complete_next    = complete;
    if (s1_func == twh_pkg::FUNC_START) begin
      hash_acc_next    = '0;
      words_left_next  = word_count;
      second_pass_next = 1'b0;
      complete_next    = (word_count == '0);
    end else if (!complete && words_left != '0) begin
      hash_acc_next = mixed;
      if (left_dec == '0) begin
        if (second_pass) begin
          words_left_next = '0;
          complete_next   = 1'b1;
        end else begin
          // reload for pass two
          second_pass_next = 1'b1;
          words_left_next  = word_count;
          complete_next    = (word_count == '0);
        end
      end else begin
        words_left_next = left_dec;
      end
    end else begin
      complete_next = 1'b1;
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_acc    <= '0;
      words_left  <= '0;
      second_pass <= 1'b0;
      complete    <= 1'b1;
      o_valid     <= 1'b0;
    end else if (advance) begin
      o_valid <= s1_valid;
      if (s1_valid) begin
        hash_acc    <= hash_acc_next;
        words_left  <= words_left_next;
        second_pass <= second_pass_next;
        complete    <= complete_next;
      end
    end
    if (step) begin
      o_hash <= hash_acc_next;
      o_done <= complete_next;
    end
  end

  assign res.valid      = o_valid;
  assign res.hash_value = o_hash;
  assign res.done_res   = o_done;

  // An unfinished hash always has words left to take
  a_busy_has_words: assert property (@(posedge clk) disable iff (rst)
    !complete |-> words_left != '0)
    else $error("hash busy with no words left");

  // Input stalls only when both registers are occupied and the output is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> s1_valid && o_valid && !res.ready)
    else $error("input stalled without cause");

  // Hash state moves only when a request is processed
  a_hash_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(step)) |-> $stable(hash_acc))
    else $error("hash changed with no request processed");

  // Pass two ends only through a start request or reset
  a_pass_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(second_pass) |->
      ($past(rst) || ($past(step) && $past(s1_func) == twh_pkg::FUNC_START)))
    else $error("second pass cleared without start");

  // Result flag matches the state it was taken from
  a_done_match: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(step)) |-> o_done == complete)
    else $error("done flag differs from state");

endmodule

`default_nettype wire

FILE: rtl/twh_mix.sv
`default_nettype none

// Per-word hash update: add, half-word carry/subtract/add, rotate left one
module twh_mix (
  input  wire logic [twh_pkg::HASH_W-1:0] hash_in,
  input  wire logic [twh_pkg::WORD_W-1:0] word,
  input  wire logic [twh_pkg::HALF_W-1:0] count,
  output logic      [twh_pkg::HASH_W-1:0] hash_out
);

  logic [twh_pkg::HASH_W-1:0] sum;
  logic [twh_pkg::HALF_W-1:0] lo0, hi0, lo1, hi1, lo2;
  logic [twh_pkg::HALF_W:0]   hl_sum;
  logic [twh_pkg::HASH_W-1:0] mixed;

  always_comb begin
    sum    = hash_in + {{(twh_pkg::HASH_W-twh_pkg::WORD_W){1'b0}}, word};
    lo0    = sum[twh_pkg::HALF_W-1:0];
    hi0    = sum[twh_pkg::HASH_W-1:twh_pkg::HALF_W];
    // borrow from the high half bumps the low half
    lo1    = (count > hi0) ? lo0 + 1'b1 : lo0;
    hi1    = hi0 - count;
    // fold low half into high, carry bumps the low half again
    hl_sum = {1'b0, hi1} + {1'b0, lo1};
    lo2    = hl_sum[twh_pkg::HALF_W] ? lo1 + 1'b1 : lo1;
    mixed  = {hl_sum[twh_pkg::HALF_W-1:0], lo2};
    hash_out = {mixed[twh_pkg::HASH_W-2:0], mixed[twh_pkg::HASH_W-1]};
  end

endmodule

`default_nettype wire
